@@ rtl/core/fprc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fprc_pkg
// Shared constants and controller/datapath interface types for the
// frequency promoted recency cache.
// ----------------------------------------------------------------------------
package fprc_pkg;

  localparam int CAPACITY_DEF   = 5;
  localparam int KEY_W          = 32;
  localparam int COUNT_W        = 16;
  localparam int POS_W          = 3;
  localparam int OCC_W          = 3;

  localparam logic [COUNT_W-1:0] COUNT_MAX    = {COUNT_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_ONE    = COUNT_W'(1);
  localparam logic [COUNT_W-1:0] THRESH_RESET = COUNT_W'(10);

  localparam logic ACTION_ACCESS = 1'b0;
  localparam logic ACTION_CLEAR  = 1'b1;

  typedef struct packed {
    logic capture;
    logic update;
  } fprc_cmd_t;

  typedef struct packed {
    logic out_busy;
  } fprc_sts_t;

endpackage
`default_nettype wire

@@ rtl/core/fprc_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fprc_ctrl
// Request sequencer: capture a request with its tag match, then commit the
// list update once the result register can take the response.
// ----------------------------------------------------------------------------
module fprc_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire fprc_pkg::fprc_sts_t sts,
  output fprc_pkg::fprc_cmd_t      cmd
);

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_UPDATE = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.update  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_UPDATE;
        end
      end
      S_UPDATE: begin
        if (!sts.out_busy) begin
          cmd.update = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/fprc_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fprc_dp
// Entry list, parallel tag match, count update with promotion, front insert
// with tail eviction, and the result register.
// ----------------------------------------------------------------------------
module fprc_dp #(
  parameter int CAPACITY = fprc_pkg::CAPACITY_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire fprc_pkg::fprc_cmd_t          cmd,
  output fprc_pkg::fprc_sts_t               sts,
  input  wire logic                         cfg_we,
  input  wire logic [fprc_pkg::COUNT_W-1:0] cfg_wdata,
  input  wire logic                         in_action,
  input  wire logic [fprc_pkg::KEY_W-1:0]   in_key,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              out_hit,
  output logic [fprc_pkg::POS_W-1:0]        out_position,
  output logic [fprc_pkg::COUNT_W-1:0]      out_hit_count,
  output logic                              out_evicted,
  output logic [fprc_pkg::KEY_W-1:0]        out_evicted_key,
  output logic [fprc_pkg::OCC_W-1:0]        out_occupancy
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] TOTAL_FULL = CNT_W'(CAPACITY);

  logic [fprc_pkg::KEY_W-1:0]   key_r     [CAPACITY];
  logic [fprc_pkg::KEY_W-1:0]   key_nxt   [CAPACITY];
  logic [fprc_pkg::COUNT_W-1:0] cnt_r     [CAPACITY];
  logic [fprc_pkg::COUNT_W-1:0] cnt_nxt   [CAPACITY];
  logic [CNT_W-1:0]             total_r, total_nxt;
  logic [fprc_pkg::COUNT_W-1:0] thr_r;

  logic                         req_action_r;
  logic [fprc_pkg::KEY_W-1:0]   req_key_r;
  logic [CAPACITY-1:0]          match_r, match_nxt;

  logic                         hit;
  logic                         full;
  logic                         promote;
  logic                         evict;
  logic [IDX_W-1:0]             found_idx;
  logic [fprc_pkg::COUNT_W-1:0] found_cnt;
  logic [fprc_pkg::COUNT_W-1:0] inc_cnt;
  logic [CAPACITY-1:0]          behind;
  logic [31:0]                  pos_wide;
  logic [31:0]                  occ_wide;

  logic                         out_valid_r;
  logic                         out_hit_r;
  logic [fprc_pkg::POS_W-1:0]   out_position_r;
  logic [fprc_pkg::COUNT_W-1:0] out_hit_count_r;
  logic                         out_evicted_r;
  logic [fprc_pkg::KEY_W-1:0]   out_evicted_key_r;
  logic [fprc_pkg::OCC_W-1:0]   out_occupancy_r;

  // tag match against valid entries
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match_nxt[i] = (CNT_W'(i) < total_r) && (key_r[i] == in_key);
    end
  end

  always_comb begin
    found_idx = '0;
    found_cnt = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (match_r[i]) begin
        found_idx = found_idx | IDX_W'(i);
        found_cnt = found_cnt | cnt_r[i];
      end
    end
    for (int j = 0; j < CAPACITY; j++) begin
      behind[j] = |(match_r >> j);
    end
  end

  assign hit     = |match_r;
  assign full    = (total_r == TOTAL_FULL);
  assign inc_cnt = (found_cnt == fprc_pkg::COUNT_MAX) ? found_cnt
                                                      : found_cnt + fprc_pkg::COUNT_ONE;
  assign promote = hit && !match_r[0] && (inc_cnt > thr_r) && (inc_cnt > cnt_r[0]);
  assign evict   = (req_action_r == fprc_pkg::ACTION_ACCESS) && !hit && full;

  always_comb begin
    for (int j = 0; j < CAPACITY; j++) begin
      key_nxt[j] = key_r[j];
      cnt_nxt[j] = cnt_r[j];
    end
    total_nxt = total_r;
    if (req_action_r == fprc_pkg::ACTION_CLEAR) begin
      total_nxt = '0;
    end else if (hit) begin
      if (promote) begin
        for (int j = 1; j < CAPACITY; j++) begin
          if (behind[j]) begin
            key_nxt[j] = key_r[j-1];
            cnt_nxt[j] = cnt_r[j-1];
          end
        end
        key_nxt[0] = req_key_r;
        cnt_nxt[0] = inc_cnt;
      end else begin
        for (int j = 0; j < CAPACITY; j++) begin
          if (match_r[j]) begin
            cnt_nxt[j] = inc_cnt;
          end
        end
      end
    end else begin
      for (int j = 1; j < CAPACITY; j++) begin
        key_nxt[j] = key_r[j-1];
        cnt_nxt[j] = cnt_r[j-1];
      end
      key_nxt[0] = req_key_r;
      cnt_nxt[0] = fprc_pkg::COUNT_ONE;
      if (!full) begin
        total_nxt = total_r + CNT_W'(1);
      end
    end
  end

  assign pos_wide = (promote || !hit) ? 32'd0 : 32'(found_idx);
  assign occ_wide = 32'(total_nxt);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_action_r <= in_action;
      req_key_r    <= in_key;
      match_r      <= match_nxt;
    end
    if (cmd.update) begin
      for (int j = 0; j < CAPACITY; j++) begin
        key_r[j] <= key_nxt[j];
        cnt_r[j] <= cnt_nxt[j];
      end
      out_hit_r         <= (req_action_r == fprc_pkg::ACTION_ACCESS) && hit;
      out_position_r    <= (req_action_r == fprc_pkg::ACTION_CLEAR) ? '0
                                                                    : pos_wide[2:0];
      out_hit_count_r   <= (req_action_r == fprc_pkg::ACTION_CLEAR) ? '0 :
                           hit ? inc_cnt : fprc_pkg::COUNT_ONE;
      out_evicted_r     <= evict;
      out_evicted_key_r <= evict ? key_r[CAPACITY-1] : '0;
      out_occupancy_r   <= occ_wide[2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      thr_r       <= fprc_pkg::THRESH_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.update) begin
        total_r <= total_nxt;
      end
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
      if (cmd.update) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.out_busy    = out_valid_r && !out_ready;
  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_position    = out_position_r;
  assign out_hit_count   = out_hit_count_r;
  assign out_evicted     = out_evicted_r;
  assign out_evicted_key = out_evicted_key_r;
  assign out_occupancy   = out_occupancy_r;

endmodule
`default_nettype wire

@@ rtl/core/frequency_promoted_recency_cache.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frequency_promoted_recency_cache
// Small fully associative key list with hit counting, promotion to the front
// and front insert with tail eviction.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one request: in_action selects
//   access or clear, in_key is the key to look up. Result channel
//   (out_valid/out_ready) returns one response per request.
//   cfg_we/cfg_wdata write the promotion threshold; write only while idle.
//   An accepted request is captured with its tag match; the response is
//   registered by the update that follows. The sequencer finishes the update
//   before it takes the next request; all tags are compared in parallel.
//   The response sits in an output register, so the next request is taken
//   while it waits. If the receiver stalls, the update of the following
//   request holds until the output register drains.
//   Reset empties the list and sets the threshold to 10; no clearing pass.
//   position and occupancy report the low 3 bits of their values.
// ----------------------------------------------------------------------------
module frequency_promoted_recency_cache #(
  parameter int CAPACITY = fprc_pkg::CAPACITY_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [fprc_pkg::COUNT_W-1:0] cfg_wdata,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         in_action,
  input  wire logic [fprc_pkg::KEY_W-1:0]   in_key,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              out_hit,
  output logic [fprc_pkg::POS_W-1:0]        out_position,
  output logic [fprc_pkg::COUNT_W-1:0]      out_hit_count,
  output logic                              out_evicted,
  output logic [fprc_pkg::KEY_W-1:0]        out_evicted_key,
  output logic [fprc_pkg::OCC_W-1:0]        out_occupancy
);

  fprc_pkg::fprc_cmd_t cmd;
  fprc_pkg::fprc_sts_t sts;

  fprc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fprc_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_action       (in_action),
    .in_key          (in_key),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_hit         (out_hit),
    .out_position    (out_position),
    .out_hit_count   (out_hit_count),
    .out_evicted     (out_evicted),
    .out_evicted_key (out_evicted_key),
    .out_occupancy   (out_occupancy)
  );

endmodule
`default_nettype wire

@@ rtl/core/fprc_chk.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fprc_chk
// Port-level checks for the frequency promoted recency cache.
// ----------------------------------------------------------------------------
module fprc_chk #(
  parameter int CAPACITY = fprc_pkg::CAPACITY_DEF
) (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic                         out_hit,
  input wire logic [fprc_pkg::POS_W-1:0]   out_position,
  input wire logic [fprc_pkg::COUNT_W-1:0] out_hit_count,
  input wire logic                         out_evicted,
  input wire logic [fprc_pkg::KEY_W-1:0]   out_evicted_key,
  input wire logic [fprc_pkg::OCC_W-1:0]   out_occupancy
);

  // one request in flight: ready drops after every accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while previous one in flight");

  // an eviction only comes from a miss, which lands at the front with count one
  a_evict_is_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_evicted) |->
      (!out_hit && out_position == '0 && out_hit_count == fprc_pkg::COUNT_ONE))
    else $error("eviction on a response that is not a miss");

  // a zero count only comes from a clear, which empties the list
  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit_count == '0) |->
      (!out_hit && !out_evicted && out_occupancy == '0 && out_evicted_key == '0))
    else $error("zero count response with nonempty list");

  // occupancy never exceeds the list size (checked only for capacities up to 7)
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((CAPACITY > 7) || (32'(out_occupancy) <= 32'(CAPACITY))))
    else $error("occupancy above capacity");

  // stalled response holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_hit_count) && $stable(out_evicted_key)
       && $stable(out_position) && $stable(out_occupancy)))
    else $error("stalled response changed");

endmodule

bind frequency_promoted_recency_cache fprc_chk #(.CAPACITY(CAPACITY)) u_fprc_chk (.*);
`default_nettype wire

@@ tb/tb_frequency_promoted_recency_cache.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_frequency_promoted_recency_cache
// Drives access and clear requests into the recency cache and checks every
// response against a cycle-free model of the key list. The model tracks keys,
// hit counts, occupancy and the promotion threshold. Directed tests cover
// fill and eviction, front hits, promotion rules, clear and count growth
// on the front entry. Random phases then use small hot key pools under
// several thresholds, with random stalls on both channels in all but the last.
// ----------------------------------------------------------------------------
module tb_frequency_promoted_recency_cache;

  localparam int LIST_DEPTH = fprc_pkg::CAPACITY_DEF;

  typedef struct packed {
    logic                         hit;
    logic [fprc_pkg::POS_W-1:0]   position;
    logic [fprc_pkg::COUNT_W-1:0] hit_count;
    logic                         evicted;
    logic [fprc_pkg::KEY_W-1:0]   evicted_key;
    logic [fprc_pkg::OCC_W-1:0]   occupancy;
  } cache_result_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         cfg_we = 1'b0;
  logic [fprc_pkg::COUNT_W-1:0] cfg_wdata = '0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic                         in_action = fprc_pkg::ACTION_ACCESS;
  logic [fprc_pkg::KEY_W-1:0]   in_key = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b1;
  logic                         out_hit;
  logic [fprc_pkg::POS_W-1:0]   out_position;
  logic [fprc_pkg::COUNT_W-1:0] out_hit_count;
  logic                         out_evicted;
  logic [fprc_pkg::KEY_W-1:0]   out_evicted_key;
  logic [fprc_pkg::OCC_W-1:0]   out_occupancy;

  logic [fprc_pkg::KEY_W-1:0]   list_keys [LIST_DEPTH];
  logic [fprc_pkg::COUNT_W-1:0] list_counts [LIST_DEPTH];
  int                           list_fill = 0;
  logic [fprc_pkg::COUNT_W-1:0] promote_level = fprc_pkg::THRESH_RESET;
  cache_result_t                pending_results [$];
  int                           mismatches = 0;
  bit                           stalls_on = 1'b0;

  frequency_promoted_recency_cache uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_key         (in_key),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hit        (out_hit),
    .out_position   (out_position),
    .out_hit_count  (out_hit_count),
    .out_evicted    (out_evicted),
    .out_evicted_key(out_evicted_key),
    .out_occupancy  (out_occupancy)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #8_000_000;
    $display("** frequency_promoted_recency_cache: FAILED **");
    $finish;
  end

  task automatic predict_request(input logic action,
                                 input logic [fprc_pkg::KEY_W-1:0] key);
    cache_result_t                res;
    int                           found;
    logic [fprc_pkg::COUNT_W-1:0] cnt;
    res = '0;
    found = -1;
    if (action == fprc_pkg::ACTION_CLEAR) begin
      list_fill = 0;
    end else begin
      for (int i = 0; i < list_fill; i++)
        if (found < 0 && list_keys[i] == key) found = i;
      if (found >= 0) begin
        cnt = list_counts[found];
        if (cnt != fprc_pkg::COUNT_MAX) cnt = cnt + 1'b1;
        list_counts[found] = cnt;
        res.hit = 1'b1;
        res.position = fprc_pkg::POS_W'(found);
        if (found > 0 && cnt > promote_level && cnt > list_counts[0]) begin
          for (int i = found; i > 0; i--) begin
            list_keys[i] = list_keys[i-1];
            list_counts[i] = list_counts[i-1];
          end
          list_keys[0] = key;
          list_counts[0] = cnt;
          res.position = '0;
        end
        res.hit_count = cnt;
      end else begin
        if (list_fill == LIST_DEPTH) begin
          res.evicted = 1'b1;
          res.evicted_key = list_keys[LIST_DEPTH-1];
          list_fill = LIST_DEPTH - 1;
        end
        for (int i = list_fill; i > 0; i--) begin
          list_keys[i] = list_keys[i-1];
          list_counts[i] = list_counts[i-1];
        end
        list_keys[0] = key;
        list_counts[0] = fprc_pkg::COUNT_ONE;
        list_fill++;
        res.hit_count = fprc_pkg::COUNT_ONE;
      end
    end
    res.occupancy = fprc_pkg::OCC_W'(list_fill);
    pending_results.push_back(res);
  endtask

  task automatic check_field(input string name, input logic [fprc_pkg::KEY_W-1:0] exp_v,
                             input logic [fprc_pkg::KEY_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    cache_result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected response, expected none actual hit=%0b key=%0h",
                 $time, out_hit, out_evicted_key);
        mismatches++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("hit", exp_r.hit, out_hit);
        check_field("position", exp_r.position, out_position);
        check_field("hit_count", exp_r.hit_count, out_hit_count);
        check_field("evicted", exp_r.evicted, out_evicted);
        check_field("evicted_key", exp_r.evicted_key, out_evicted_key);
        check_field("occupancy", exp_r.occupancy, out_occupancy);
      end
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      if (stalls_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 10)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_request(input logic action, input logic [fprc_pkg::KEY_W-1:0] key);
    if (stalls_on && $urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 11)) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    @(negedge clk);
    in_valid  <= 1'b1;
    in_action <= action;
    in_key    <= key;
    do @(posedge clk); while (!in_ready);
    predict_request(action, key);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_threshold(input logic [fprc_pkg::COUNT_W-1:0] level);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= level;
    @(negedge clk);
    cfg_we <= 1'b0;
    promote_level = level;
  endtask

  task automatic test_fill_and_evict();
    send_request(fprc_pkg::ACTION_CLEAR, 32'h0);
    send_request(fprc_pkg::ACTION_ACCESS, 32'h0000_0000);
    send_request(fprc_pkg::ACTION_ACCESS, 32'hFFFF_FFFF);
    send_request(fprc_pkg::ACTION_ACCESS, 32'h0000_0001);
    send_request(fprc_pkg::ACTION_ACCESS, 32'h0000_0002);
    send_request(fprc_pkg::ACTION_ACCESS, 32'h8000_0000);
    send_request(fprc_pkg::ACTION_ACCESS, 32'h5555_5555);
    send_request(fprc_pkg::ACTION_ACCESS, 32'h0000_0000);
    send_request(fprc_pkg::ACTION_ACCESS, 32'h0000_0001);
  endtask

  task automatic test_front_hit();
    send_request(fprc_pkg::ACTION_ACCESS, 32'hAAAA_AAAA);
    send_request(fprc_pkg::ACTION_ACCESS, 32'hAAAA_AAAA);
  endtask

  task automatic test_promotion();
    write_threshold(16'd2);
    send_request(fprc_pkg::ACTION_CLEAR, 32'hFFFF_FFFF);
    send_request(fprc_pkg::ACTION_ACCESS, 32'h0000_00A0);
    send_request(fprc_pkg::ACTION_ACCESS, 32'h0000_00B0);
    send_request(fprc_pkg::ACTION_ACCESS, 32'h0000_00C0);
    repeat (2) send_request(fprc_pkg::ACTION_ACCESS, 32'h0000_00A0);
    repeat (3) send_request(fprc_pkg::ACTION_ACCESS, 32'h0000_00B0);
    send_request(fprc_pkg::ACTION_ACCESS, 32'h0000_00B0);
  endtask

  task automatic test_clear();
    send_request(fprc_pkg::ACTION_CLEAR, 32'hFFFF_FFFF);
    send_request(fprc_pkg::ACTION_CLEAR, 32'h0000_0000);
  endtask

  task automatic test_front_count();
    write_threshold(fprc_pkg::THRESH_RESET);
    send_request(fprc_pkg::ACTION_CLEAR, 32'h0);
    repeat (20) send_request(fprc_pkg::ACTION_ACCESS, 32'h1234_5678);
    send_request(fprc_pkg::ACTION_ACCESS, 32'h8765_4321);
    send_request(fprc_pkg::ACTION_ACCESS, 32'h1234_5678);
    send_request(fprc_pkg::ACTION_ACCESS, 32'h8765_4321);
  endtask

  task automatic run_random_phase(input int count,
                                  input logic [fprc_pkg::COUNT_W-1:0] level,
                                  input bit stalls);
    logic [fprc_pkg::KEY_W-1:0] hot_keys [8];
    int                         pool_n;
    int                         pick;
    write_threshold(level);
    stalls_on = stalls;
    pool_n = $urandom_range(4, 8);
    foreach (hot_keys[i]) hot_keys[i] = $urandom;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 3)
        send_request(fprc_pkg::ACTION_CLEAR, $urandom);
      else if (pick < 88)
        send_request(fprc_pkg::ACTION_ACCESS,
                     hot_keys[$urandom_range(0, $urandom_range(0, pool_n - 1))]);
      else
        send_request(fprc_pkg::ACTION_ACCESS, $urandom);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_fill_and_evict();
    test_front_hit();
    test_clear();
    test_promotion();
    test_front_count();

    run_random_phase(280, 16'd0, 1'b1);
    run_random_phase(280, 16'd3, 1'b1);
    run_random_phase(280, 16'hFFFF, 1'b1);
    run_random_phase(280, 16'd1, 1'b1);
    run_random_phase(280, 16'($urandom_range(0, 20)), 1'b1);
    run_random_phase(300, fprc_pkg::THRESH_RESET, 1'b0);

    drain_results();
    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("** frequency_promoted_recency_cache: PASSED **");
    else
      $display("** frequency_promoted_recency_cache: FAILED **");
    $finish;
  end

endmodule
